// ===== rtl/aps_pkg.sv =====
`timescale 1ns / 1ps

package aps_pkg;

    // Field widths
    localparam int ID_W          = 8;
    localparam int TIME_W        = 16;
    localparam int PRIO_W        = 16;
    localparam int DEF_MAX_PROCS = 8;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_RAN       = 3'd0,
        STAT_FINISHED  = 3'd1,
        STAT_IDLE_TICK = 3'd2,
        STAT_ADDED     = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    // Input request
    typedef struct packed {
        logic                     cmd;
        logic [ID_W-1:0]          proc_id_in;
        logic [TIME_W-1:0]        need_time_in;
        logic signed [PRIO_W-1:0] priority_in;
    } t_in_req;

    // Result request
    typedef struct packed {
        t_status                  status;
        logic [ID_W-1:0]          proc_id_out;
        logic [TIME_W-1:0]        remaining_out;
        logic signed [PRIO_W-1:0] priority_out;
        logic [TIME_W-1:0]        cpu_used_out;
        logic [TIME_W-1:0]        turnaround_out;
    } t_out_res;

    // One process record, in the queue or running
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [TIME_W-1:0]        need;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        cpu;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Queue commands from the sequencer, one-cycle pulses
    typedef struct packed {
        logic ins;
        logic pop;
        logic peek;
    } t_q_req;

    // Queue status back to the sequencer
    typedef struct packed {
        logic done;
        logic empty;
        logic full;
    } t_q_rsp;

    // Top-level sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_ISSUE,
        ST_INS_WAIT,
        ST_DISP,
        ST_RUN,
        ST_PRE,
        ST_EMIT
    } t_state;

    // Insertion engine states
    typedef enum logic [1:0] {
        INS_IDLE,
        INS_START,
        INS_CMP,
        INS_LAST
    } t_ins_state;

endpackage

// ===== rtl/aging_priority_scheduler_core.sv =====
`timescale 1ns / 1ps

// Priority scheduler with aging.
// Input channel: i_in_valid / o_in_stall carry one request (add a process or
// advance one tick). Output channel: o_out_valid / i_out_stall carry exactly
// one result per request, in request order.
// One request is worked at a time; o_in_stall is high from acceptance until
// the result is loaded into the output register.
// An add into a full queue goes straight to its result; any other add is
// placed by a walk from the tail. A tick with nothing running and an empty
// queue is an idle tick; a tick may dispatch the queue head first, and
// preemption adds the reinsertion walk. The walk is one entry per cycle,
// set by the one queue RAM read port and the one priority comparator. The
// next request is taken in the cycle after the result is loaded.
// The output register frees the sequencer: a new request is taken while a
// result waits. If i_out_stall holds the result, the next result waits in
// its final state, and o_in_stall stays high.
// Reset (i_rst_n low, synchronous) empties the queue, clears the running
// slot and the tick counter; queue storage itself is not cleared.
module aging_priority_scheduler_core #(
    parameter int MAX_PROCS = aps_pkg::DEF_MAX_PROCS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  aps_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output aps_pkg::t_out_res o_out_res
);

    aps_pkg::t_state   r_state, n_state;
    logic              r_run_valid, n_run_valid;
    aps_pkg::t_entry   r_run, n_run;
    logic [aps_pkg::TIME_W-1:0] r_elapsed, n_elapsed;
    aps_pkg::t_entry   r_ins, n_ins;
    aps_pkg::t_out_res r_res, n_res;
    aps_pkg::t_out_res r_out, n_out;
    logic              r_out_valid, n_out_valid;

    aps_pkg::t_q_req q_req;
    aps_pkg::t_q_rsp q_rsp;
    aps_pkg::t_entry q_head;

    logic            in_acc;
    logic            emit_go;
    aps_pkg::t_entry upd;

    assign in_acc  = i_in_valid && (r_state == aps_pkg::ST_IDLE);
    assign emit_go = (r_state == aps_pkg::ST_EMIT) && (!r_out_valid || !i_out_stall);

    // Age the running process by one tick, with saturation
    always_comb begin
        upd      = r_run;
        upd.cpu  = (r_run.cpu == '1) ? r_run.cpu : r_run.cpu + 1'b1;
        upd.need = (r_run.need == '0) ? r_run.need : r_run.need - 1'b1;
        upd.prio = (r_run.prio == {1'b1, {(aps_pkg::PRIO_W-1){1'b0}}}) ?
                   r_run.prio : r_run.prio - {{(aps_pkg::PRIO_W-1){1'b0}}, 1'b1};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aps_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_req.cmd == aps_pkg::CMD_ADD) begin
                        n_state = q_rsp.full ? aps_pkg::ST_EMIT : aps_pkg::ST_INS_ISSUE;
                    end else if (r_run_valid) begin
                        n_state = aps_pkg::ST_RUN;
                    end else if (q_rsp.empty) begin
                        n_state = aps_pkg::ST_EMIT;
                    end else begin
                        n_state = aps_pkg::ST_DISP;
                    end
                end
            end
            aps_pkg::ST_INS_ISSUE: n_state = aps_pkg::ST_INS_WAIT;
            aps_pkg::ST_INS_WAIT: begin
                if (q_rsp.done) begin
                    n_state = aps_pkg::ST_EMIT;
                end
            end
            aps_pkg::ST_DISP: n_state = aps_pkg::ST_RUN;
            aps_pkg::ST_RUN: begin
                if (upd.need == '0 || q_rsp.empty) begin
                    n_state = aps_pkg::ST_EMIT;
                end else begin
                    n_state = aps_pkg::ST_PRE;
                end
            end
            aps_pkg::ST_PRE: begin
                n_state = (r_run.prio <= q_head.prio) ? aps_pkg::ST_INS_ISSUE
                                                      : aps_pkg::ST_EMIT;
            end
            aps_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = aps_pkg::ST_IDLE;
                end
            end
            default: n_state = aps_pkg::ST_IDLE;
        endcase
    end

    // Queue commands
    always_comb begin
        q_req = '0;
        unique case (r_state)
            aps_pkg::ST_IDLE: begin
                q_req.peek = in_acc && (i_in_req.cmd == aps_pkg::CMD_TICK) &&
                             !r_run_valid && !q_rsp.empty;
            end
            aps_pkg::ST_INS_ISSUE: q_req.ins = 1'b1;
            aps_pkg::ST_DISP:      q_req.pop = 1'b1;
            aps_pkg::ST_RUN:       q_req.peek = (upd.need != '0) && !q_rsp.empty;
            aps_pkg::ST_PRE:       q_req.pop = (r_run.prio <= q_head.prio);
            default:               q_req = '0;
        endcase
    end

    // Datapath updates
    always_comb begin
        n_run_valid = r_run_valid;
        n_run       = r_run;
        n_elapsed   = r_elapsed;
        n_ins       = r_ins;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            aps_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    if (i_in_req.cmd == aps_pkg::CMD_ADD) begin
                        n_ins.id   = i_in_req.proc_id_in;
                        n_ins.need = i_in_req.need_time_in;
                        n_ins.prio = i_in_req.priority_in;
                        n_ins.cpu  = '0;
                        n_res.proc_id_out = i_in_req.proc_id_in;
                        if (q_rsp.full) begin
                            n_res.status = aps_pkg::STAT_FULL;
                        end else begin
                            n_res.status        = aps_pkg::STAT_ADDED;
                            n_res.remaining_out = i_in_req.need_time_in;
                            n_res.priority_out  = i_in_req.priority_in;
                        end
                    end else begin
                        n_elapsed    = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
                        n_res.status = aps_pkg::STAT_IDLE_TICK;
                    end
                end
            end
            aps_pkg::ST_DISP: begin
                // take the queue head into the running slot
                n_run       = q_head;
                n_run_valid = 1'b1;
            end
            aps_pkg::ST_RUN: begin
                n_run               = upd;
                n_res.proc_id_out   = upd.id;
                n_res.remaining_out = upd.need;
                n_res.priority_out  = upd.prio;
                n_res.cpu_used_out  = upd.cpu;
                if (upd.need == '0) begin
                    n_res.status         = aps_pkg::STAT_FINISHED;
                    n_res.turnaround_out = r_elapsed;
                    n_run_valid          = 1'b0;
                end else begin
                    n_res.status         = aps_pkg::STAT_RAN;
                    n_res.turnaround_out = '0;
                end
            end
            aps_pkg::ST_PRE: begin
                // preempt: head runs, old process goes back to the queue
                if (r_run.prio <= q_head.prio) begin
                    n_ins = r_run;
                    n_run = q_head;
                end
            end
            aps_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: n_run_valid = r_run_valid;
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aps_pkg::ST_IDLE;
            r_run_valid <= 1'b0;
            r_run       <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_run       <= n_run;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_ins <= n_ins;
        r_res <= n_res;
        r_out <= n_out;
    end

    aps_queue #(
        .MAX_PROCS(MAX_PROCS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (q_req),
        .i_entry   (r_ins),
        .o_rsp     (q_rsp),
        .o_rd_data (q_head)
    );

    assign o_in_stall  = (r_state != aps_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Dispatch only from a non-empty queue
    a_disp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aps_pkg::ST_DISP) |-> !q_rsp.empty)
        else $error("dispatch from empty queue");

    // Aging always acts on a running process
    a_run_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aps_pkg::ST_RUN) |-> r_run_valid)
        else $error("tick with nothing running");

    // Tick counter never goes backward
    a_elapsed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_elapsed >= $past(r_elapsed))
        else $error("tick counter decreased");

    // A result is loaded only into a free or draining output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aps_pkg::ST_EMIT && r_out_valid && i_out_stall)
        |=> (r_state == aps_pkg::ST_EMIT))
        else $error("result overwrote a stalled output");

endmodule

// ===== rtl/aps_ram.sv =====
`timescale 1ns / 1ps

module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/aps_queue.sv =====
`timescale 1ns / 1ps

module aps_queue #(
    parameter int MAX_PROCS = aps_pkg::DEF_MAX_PROCS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aps_pkg::t_q_req i_req,
    input  aps_pkg::t_entry i_entry,
    output aps_pkg::t_q_rsp o_rsp,
    output aps_pkg::t_entry o_rd_data
);

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    aps_pkg::t_ins_state r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    aps_pkg::t_entry     r_entry, n_entry;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    aps_pkg::t_entry wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    aps_pkg::t_entry rd_data;
    logic            done;

    // Map a queue position to a RAM address, ring wraps at the depth
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] ofs);
        logic [AW+1:0] sum;
        sum = {2'b00, head} + {{(AW+2-CW){1'b0}}, ofs};
        if (sum >= (AW+2)'(MAX_PROCS)) begin
            sum = sum - (AW+2)'(MAX_PROCS);
        end
        return sum[AW-1:0];
    endfunction

    // Insert walks from the tail toward the head, one entry per cycle
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_k     = r_k;
        n_entry = r_entry;
        wr_en   = 1'b0;
        wr_addr = f_phys(r_head, r_k);
        wr_data = r_entry;
        rd_en   = 1'b0;
        rd_addr = r_head;
        done    = 1'b0;
        unique case (r_state)
            aps_pkg::INS_IDLE: begin
                if (i_req.peek) begin
                    rd_en = 1'b1;
                end
                if (i_req.pop) begin
                    n_head  = f_phys(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                end
                if (i_req.ins) begin
                    n_entry = i_entry;
                    n_k     = r_count;
                    n_state = aps_pkg::INS_START;
                end
            end
            aps_pkg::INS_START: begin
                if (r_k == '0) begin
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = aps_pkg::INS_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = f_phys(r_head, r_k - CW'(1));
                    n_state = aps_pkg::INS_CMP;
                end
            end
            aps_pkg::INS_CMP: begin
                wr_en = 1'b1;
                if (rd_data.prio >= r_entry.prio) begin
                    // stop behind an entry of greater or equal priority
                    done    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = aps_pkg::INS_IDLE;
                end else begin
                    // move the entry one place toward the tail
                    wr_data = rd_data;
                    if (r_k == CW'(1)) begin
                        n_state = aps_pkg::INS_LAST;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = f_phys(r_head, r_k - CW'(2));
                        n_k     = r_k - CW'(1);
                    end
                end
            end
            aps_pkg::INS_LAST: begin
                wr_en   = 1'b1;
                wr_addr = r_head;
                done    = 1'b1;
                n_count = r_count + CW'(1);
                n_state = aps_pkg::INS_IDLE;
            end
            default: n_state = aps_pkg::INS_IDLE;
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aps_pkg::INS_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Hold insert payload
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_entry <= n_entry;
    end

    aps_ram #(
        .WIDTH(aps_pkg::ENTRY_W),
        .DEPTH(MAX_PROCS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_rsp.done  = done;
    assign o_rsp.empty = (r_count == '0);
    assign o_rsp.full  = (r_count == CW'(MAX_PROCS));
    assign o_rd_data   = rd_data;

    // Insert only into a queue with room, while the engine is free
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ins |-> (!o_rsp.full && r_state == aps_pkg::INS_IDLE))
        else $error("insert into full or busy queue");

    // Count never exceeds the depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROCS))
        else $error("queue count overflow");

    // A finished insert adds exactly one entry
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_count == $past(r_count) + CW'(1))
        else $error("insert count mismatch");

endmodule
